[hw/rtl/ofrb_pkg.sv]
package ofrb_pkg;

  // Fixed field widths of the request and response.
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 7;
  localparam int LEVEL_W  = 11;

  // Request actions.
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_FILL  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // One request on the input channel.
  typedef struct packed {
    action_t              action;
    logic [SAMPLE_W-1:0]  sample;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   overlap;
  } in_req_t;

  // One response word on the output channel.
  typedef struct packed {
    logic [SAMPLE_W-1:0]  sample_out;
    logic                 last;
    logic                 status;
    logic [LEVEL_W-1:0]   level;
  } out_rsp_t;

endpackage

[hw/rtl/ofrb_div.sv]
module ofrb_div import ofrb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COUNT_W-1:0] dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               done,
  output logic [COUNT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(COUNT_W);

  logic               run_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] quo_r;
  logic [COUNT_W-1:0] dsr_r;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, quo_r[COUNT_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = (trial >= {1'b0, dsr_r});
  end

  // Sequencer: one quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (run_r) begin
        rem_r  <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
        quo_r  <= {quo_r[COUNT_W-2:0], fits};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(COUNT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/ofrb_store.sv]
module ofrb_store import ofrb_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [SAMPLE_W-1:0] wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output logic [SAMPLE_W-1:0] rdata
);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/overlapped_frame_ring_buffer.sv]
// Circular store of DEPTH 32-bit samples with overlapped frame reads. A push
// request stores one sample and a fill request stores one value count times;
// either is rejected with status 1, leaving the state untouched, when it would
// exceed the free space. A clear request resets both pointers and the level.
// A frame read returns min(count, MAX_FRAME) words from the read pointer,
// wrapping at DEPTH and padding with zeros past the stored level, then moves
// the read pointer forward and lowers the level by floor(copied / overlap).
// Every request yields one response word except a frame read, which yields
// one per frame word with last set on the final one; level is the level after
// the request. One request is handled at a time. Push and clear go straight
// to their response, a fill writes one word per cycle on the single memory
// write port, and a frame read waits on the bit-serial divider (7 quotient
// steps and a done strobe) and then steps through address, registered memory
// read and output handshake states for each word, holding while the output
// is stalled. There is no clearing pass after reset; entries beyond the
// stored level are never returned.
module overlapped_frame_ring_buffer import ofrb_pkg::*; #(
  parameter int DEPTH     = 1024,
  parameter int MAX_FRAME = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = LVL_W + COUNT_W;
  localparam int SUM_W  = ((ADDR_W > COUNT_W) ? ADDR_W : COUNT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DIV,
    S_ADDR,
    S_LOAD,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   wr_ptr_r;
  logic [ADDR_W-1:0]   rd_ptr_r;
  logic [LVL_W-1:0]    level_r;
  logic [ADDR_W-1:0]   cur_r;
  logic [COUNT_W-1:0]  remain_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [COUNT_W-1:0]  copied_r;
  logic [COUNT_W-1:0]  idx_r;
  logic [SAMPLE_W-1:0] fill_val_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_word_r;
  logic                out_last_r;
  logic                out_status_r;

  logic                accept;
  logic [COUNT_W-1:0]  count_sat;
  logic [COUNT_W-1:0]  ovl;
  logic [LVL_W-1:0]    free_words;
  logic [COUNT_W-1:0]  need;
  logic                reject;
  logic [COUNT_W-1:0]  copied;
  logic                div_start;
  logic                div_done;
  logic [COUNT_W-1:0]  hop;
  logic [SUM_W-1:0]    rd_sum;
  logic [ADDR_W-1:0]   rd_ptr_adv;
  logic                mem_we;
  logic [SAMPLE_W-1:0] mem_wdata;
  logic [SAMPLE_W-1:0] mem_rdata;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    ptr_inc = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Request decode: saturated frame length, space check and copied count.
  always_comb begin
    count_sat  = (in_data.count > COUNT_W'(MAX_FRAME)) ? COUNT_W'(MAX_FRAME)
                                                       : in_data.count;
    ovl        = (in_data.overlap == '0) ? COUNT_W'(1) : in_data.overlap;
    free_words = LVL_W'(DEPTH) - level_r;
    need       = (in_data.action == ACT_PUSH) ? COUNT_W'(1) : in_data.count;
    reject     = (CMP_W'(need) > CMP_W'(free_words));
    copied     = (CMP_W'(level_r) < CMP_W'(count_sat)) ? COUNT_W'(level_r)
                                                       : count_sat;
  end

  assign div_start = accept && (in_data.action == ACT_READ) && (count_sat != '0);

  // Read pointer advance by the hop; hop never exceeds DEPTH.
  always_comb begin
    rd_sum     = SUM_W'(rd_ptr_r) + SUM_W'(hop);
    rd_ptr_adv = (rd_sum >= SUM_W'(DEPTH)) ? ADDR_W'(rd_sum - SUM_W'(DEPTH))
                                           : ADDR_W'(rd_sum);
  end

  // Memory write on an accepted push that is not rejected, or on each fill cycle.
  assign mem_we = (accept && (in_data.action == ACT_PUSH) && !reject) ||
                  (state_r == S_FILL);
  assign mem_wdata = (state_r == S_FILL) ? fill_val_r : in_data.sample;

  ofrb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (copied),
    .divisor  (ovl),
    .done     (div_done),
    .quotient (hop)
  );

  ofrb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_ptr_r),
    .wdata (mem_wdata),
    .raddr (cur_r),
    .rdata (mem_rdata)
  );

  // Sequencer, buffer state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_word_r   <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= 1'b0;
            case (in_data.action)
              ACT_PUSH: begin
                if (!reject) begin
                  wr_ptr_r <= ptr_inc(wr_ptr_r);
                  level_r  <= level_r + LVL_W'(1);
                end
                out_status_r <= reject;
                out_valid_r  <= 1'b1;
                state_r      <= S_EMIT;
              end
              ACT_FILL: begin
                if (reject || (in_data.count == '0)) begin
                  out_status_r <= reject;
                  out_valid_r  <= 1'b1;
                  state_r      <= S_EMIT;
                end else begin
                  fill_val_r <= in_data.sample;
                  remain_r   <= in_data.count;
                  state_r    <= S_FILL;
                end
              end
              ACT_READ: begin
                if (count_sat != '0) begin
                  cnt_r    <= count_sat;
                  copied_r <= copied;
                  cur_r    <= rd_ptr_r;
                  idx_r    <= '0;
                  state_r  <= S_DIV;
                end
              end
              ACT_CLEAR: begin
                wr_ptr_r    <= '0;
                rd_ptr_r    <= '0;
                level_r     <= '0;
                out_valid_r <= 1'b1;
                state_r     <= S_EMIT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_FILL: begin
          wr_ptr_r <= ptr_inc(wr_ptr_r);
          level_r  <= level_r + LVL_W'(1);
          remain_r <= remain_r - COUNT_W'(1);
          if (remain_r == COUNT_W'(1)) begin
            out_valid_r <= 1'b1;
            state_r     <= S_EMIT;
          end
        end
        S_DIV: begin
          // The level shown on every frame word is the level after the read.
          if (div_done) begin
            rd_ptr_r <= rd_ptr_adv;
            level_r  <= level_r - LVL_W'(hop);
            state_r  <= S_ADDR;
          end
        end
        S_ADDR: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          out_word_r   <= (idx_r < copied_r) ? mem_rdata : '0;
          out_last_r   <= (idx_r == cnt_r - COUNT_W'(1));
          out_status_r <= 1'b0;
          out_valid_r  <= 1'b1;
          state_r      <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + COUNT_W'(1);
              cur_r   <= ptr_inc(cur_r);
              state_r <= S_ADDR;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Response payload.
  assign out_valid           = out_valid_r;
  assign out_data.sample_out = out_word_r;
  assign out_data.last       = out_last_r;
  assign out_data.status     = out_status_r;
  assign out_data.level      = LEVEL_W'(level_r);

endmodule

[dv/overlapped_frame_ring_buffer_tb.sv]
module overlapped_frame_ring_buffer_tb;
  import ofrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 1024;
  localparam int MAX_FRAME      = 64;
  localparam int RANDOM_REQS    = 155;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;

  // One queued request plus the idle cycles that follow its acceptance.
  typedef struct {
    in_req_t     req;
    int unsigned gap;
    bit          drain;
  } stim_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  // Shadow copy of the ring state.
  logic [SAMPLE_W-1:0] ring_mem [DEPTH];
  int unsigned         ring_wr;
  int unsigned         ring_rd;
  int unsigned         ring_lvl;

  stim_t       stim_q[$];
  out_rsp_t    rsp_due_q[$];
  bit          rsp_all_done = 1'b1;
  int unsigned stim_total;
  int unsigned reqs_taken;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned cyc;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned rejects_seen;
  int unsigned act_seen [4];

  overlapped_frame_ring_buffer #(
    .DEPTH    (DEPTH),
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, a few long ones; a calm stretch has none at all.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_req(input action_t act, input logic [SAMPLE_W-1:0] smp,
                           input int unsigned cnt, input int unsigned ovl,
                           input int unsigned gap, input bit drain);
    stim_t s;
    s.req.action  = act;
    s.req.sample  = smp;
    s.req.count   = cnt[COUNT_W-1:0];
    s.req.overlap = ovl[COUNT_W-1:0];
    s.gap         = gap;
    s.drain       = drain;
    stim_q.push_back(s);
    stim_total++;
  endtask

  // Applies one request to the shadow ring and queues the responses it owes.
  task automatic ring_apply(input in_req_t req);
    out_rsp_t            rsp;
    logic [SAMPLE_W-1:0] frame_buf [MAX_FRAME];
    int unsigned         n;
    int unsigned         ovl;
    int unsigned         copied;
    int unsigned         hop;
    int unsigned         i;
    rsp      = '0;
    rsp.last = 1'b1;
    case (req.action)
      ACT_PUSH, ACT_FILL: begin
        n = (req.action == ACT_PUSH) ? 1 : req.count;
        if (n > DEPTH - ring_lvl) begin
          rsp.status = 1'b1;
        end else begin
          for (i = 0; i < n; i++) begin
            ring_mem[ring_wr] = req.sample;
            ring_wr = (ring_wr + 1) % DEPTH;
          end
          ring_lvl += n;
        end
        rsp.level = LEVEL_W'(ring_lvl);
        rsp_due_q.push_back(rsp);
      end
      ACT_CLEAR: begin
        ring_wr  = 0;
        ring_rd  = 0;
        ring_lvl = 0;
        rsp_due_q.push_back(rsp);
      end
      default: begin
        // Frame read: saturate the length, then copy what is stored and pad.
        n = (req.count > MAX_FRAME) ? MAX_FRAME : req.count;
        if (n == 0) return;
        ovl    = (req.overlap == 0) ? 1 : req.overlap;
        copied = (n < ring_lvl) ? n : ring_lvl;
        for (i = 0; i < n; i++)
          frame_buf[i] = (i < copied) ? ring_mem[(ring_rd + i) % DEPTH] : '0;
        hop      = copied / ovl;
        ring_rd  = (ring_rd + hop) % DEPTH;
        ring_lvl = ring_lvl - hop;
        for (i = 0; i < n; i++) begin
          rsp.sample_out = frame_buf[i];
          rsp.last       = (i + 1 == n);
          rsp.level      = LEVEL_W'(ring_lvl);
          rsp_due_q.push_back(rsp);
        end
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Request driver: holds each request until taken, then idles for its gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() != 0 &&
                   (!stim_q[0].drain || (!in_valid && rsp_all_done))) begin
        in_valid <= 1'b1;
        in_data  <= stim_q[0].req;
        gap_left <= stim_q[0].gap;
        void'(stim_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Response backpressure: random stalls, with a stall-free window now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      cyc        <= 0;
    end else begin
      cyc <= cyc + 1;
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ((cyc / 400) % 4 != 1 && $urandom_range(0, 99) < 25) begin
        out_ready  <= 1'b0;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check each response against the oldest one owed, then predict
  // the responses of a request taken at this edge.
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $time, out_data);
          mismatches++;
        end else begin
          want = rsp_due_q.pop_front();
          check_field("sample_out", want.sample_out, out_data.sample_out);
          check_field("last", 32'(want.last), 32'(out_data.last));
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("level", 32'(want.level), 32'(out_data.level));
          words_checked++;
          if (out_data.status) rejects_seen++;
        end
      end
      if (in_valid && in_ready) begin
        ring_apply(in_data);
        act_seen[in_data.action]++;
        reqs_taken++;
      end
    end
    rsp_all_done <= (rsp_due_q.size() == 0);
  end

  // Watchdog on cycles without any accepted request or response.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned k;
    int unsigned roll;
    int unsigned cnt;
    int unsigned ovl;
    bit          calm;
    ring_wr  = 0;
    ring_rd  = 0;
    ring_lvl = 0;

    // Directed: empty read, extreme samples, zero counts, overlap zero,
    // filling to the brim, rejects, saturated and overlapped frames.
    queue_req(ACT_READ, '0, 5, 1, 0, 1'b0);
    queue_req(ACT_PUSH, 32'hFFFF_FFFF, 1, 1, 0, 1'b0);
    queue_req(ACT_PUSH, 32'h0000_0000, 1, 1, 0, 1'b0);
    queue_req(ACT_PUSH, $urandom, 1, 1, pick_gap(1'b0), 1'b0);
    queue_req(ACT_FILL, $urandom, 0, 1, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 0, 1, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 4, 0, pick_gap(1'b0), 1'b0);
    queue_req(ACT_CLEAR, $urandom, 0, 0, 0, 1'b0);
    for (k = 0; k < 8; k++)
      queue_req(ACT_FILL, $urandom, 127, $urandom_range(0, 127), pick_gap(1'b0), 1'b0);
    queue_req(ACT_FILL, $urandom, 9, 1, 0, 1'b0);
    queue_req(ACT_FILL, $urandom, 8, 1, 0, 1'b0);
    queue_req(ACT_PUSH, $urandom, 1, 1, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 127, 127, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 64, 1, pick_gap(1'b0), 1'b0);
    queue_req(ACT_FILL, $urandom, 64, 1, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 100, 3, 0, 1'b0);
    queue_req(ACT_READ, $urandom, 64, 64, 0, 1'b0);
    queue_req(ACT_CLEAR, 32'hFFFF_FFFF, 127, 127, pick_gap(1'b0), 1'b0);

    // Random mix, weighted toward pushes and short frames. Zero-length reads
    // are not counted since the block does nothing with them.
    k = 0;
    while (k < RANDOM_REQS) begin
      roll = $urandom_range(0, 99);
      calm = (k >= 60 && k < 100);
      if (roll < 35) begin
        queue_req(ACT_PUSH, $urandom, $urandom_range(0, 127), $urandom_range(0, 127),
                  pick_gap(calm), k == 120);
        k++;
      end else if (roll < 55) begin
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 127) : $urandom_range(0, 16);
        queue_req(ACT_FILL, $urandom, cnt, $urandom_range(0, 127), pick_gap(calm), k == 120);
        k++;
      end else if (roll < 95) begin
        cnt = ($urandom_range(0, 99) < 15) ? $urandom_range(17, 127) : $urandom_range(0, 16);
        ovl = ($urandom_range(0, 99) < 20) ? $urandom_range(5, 127) : $urandom_range(0, 4);
        queue_req(ACT_READ, $urandom, cnt, ovl, pick_gap(calm), k == 120);
        if (cnt != 0) k++;
      end else begin
        queue_req(ACT_CLEAR, $urandom, $urandom_range(0, 127), $urandom_range(0, 127),
                  pick_gap(calm), k == 120);
        k++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every response to arrive, then
    // give the block time to show any stray response.
    @(negedge clk);
    while (reqs_taken != stim_total || rsp_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d pushes, %0d fills, %0d frame reads and %0d clears.",
             act_seen[ACT_PUSH], act_seen[ACT_FILL], act_seen[ACT_READ], act_seen[ACT_CLEAR]);
    $display("Checked %0d response words, %0d of them rejected writes; %0d mismatches.",
             words_checked, rejects_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ofrb_pkg.sv
hw/rtl/ofrb_div.sv
hw/rtl/ofrb_store.sv
hw/rtl/overlapped_frame_ring_buffer.sv
dv/overlapped_frame_ring_buffer_tb.sv
